// File: design/aes_pkg.sv
package aes_pkg;

	typedef logic [127:0] blk_t;

	localparam logic KIND_ENC = 1'b0;
	localparam logic KIND_DEC = 1'b1;
	localparam logic CFG_KEY_HIGH = 1'b0;
	localparam logic CFG_KEY_LOW = 1'b1;
	localparam int NumRounds = 10;

	localparam logic [7:0] FWD_SUB [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] REV_SUB [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	localparam logic [7:0] RCON [10] = '{
		8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
	};

	// byte i of a block sits at bits 127-8i..120-8i
	function automatic logic [7:0] get_byte(input blk_t b, input int i);
		return b[127-8*i -: 8];
	endfunction

	function automatic logic [7:0] xt(input logic [7:0] v);
		return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
	endfunction

	// encryption round, or decryption inverse shift and sub; no key add
	function automatic blk_t round_fn(input blk_t s, input logic dec, input logic last);
		blk_t o;
		logic [7:0] a0, a1, a2, a3, all;
		o = '0;
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				if (dec)
					o[127-8*(r+4*c) -: 8] = REV_SUB[get_byte(s, r + 4*((c + 3*r) & 3))];
				else
					o[127-8*(r+4*c) -: 8] = FWD_SUB[get_byte(s, r + 4*((c + r) & 3))];
			end
		end
		if (!last && !dec) begin
			for (int c = 0; c < 4; c++) begin
				a0 = get_byte(o, 4*c); a1 = get_byte(o, 4*c+1);
				a2 = get_byte(o, 4*c+2); a3 = get_byte(o, 4*c+3);
				all = a0 ^ a1 ^ a2 ^ a3;
				o[127-8*(4*c) -: 8] = a0 ^ all ^ xt(a0 ^ a1);
				o[127-8*(4*c+1) -: 8] = a1 ^ all ^ xt(a1 ^ a2);
				o[127-8*(4*c+2) -: 8] = a2 ^ all ^ xt(a2 ^ a3);
				o[127-8*(4*c+3) -: 8] = a3 ^ all ^ xt(a3 ^ a0);
			end
		end
		return o;
	endfunction

	// inverse mix as a preconditioning then forward mix
	function automatic blk_t inv_mix(input blk_t s);
		blk_t o, p;
		logic [7:0] a0, a1, a2, a3, all, u, v;
		p = s;
		for (int c = 0; c < 4; c++) begin
			a0 = get_byte(s, 4*c); a1 = get_byte(s, 4*c+1);
			a2 = get_byte(s, 4*c+2); a3 = get_byte(s, 4*c+3);
			u = xt(xt(a0 ^ a2));
			v = xt(xt(a1 ^ a3));
			p[127-8*(4*c) -: 8] = a0 ^ u;
			p[127-8*(4*c+1) -: 8] = a1 ^ v;
			p[127-8*(4*c+2) -: 8] = a2 ^ u;
			p[127-8*(4*c+3) -: 8] = a3 ^ v;
		end
		o = p;
		for (int c = 0; c < 4; c++) begin
			a0 = get_byte(p, 4*c); a1 = get_byte(p, 4*c+1);
			a2 = get_byte(p, 4*c+2); a3 = get_byte(p, 4*c+3);
			all = a0 ^ a1 ^ a2 ^ a3;
			o[127-8*(4*c) -: 8] = a0 ^ all ^ xt(a0 ^ a1);
			o[127-8*(4*c+1) -: 8] = a1 ^ all ^ xt(a1 ^ a2);
			o[127-8*(4*c+2) -: 8] = a2 ^ all ^ xt(a2 ^ a3);
			o[127-8*(4*c+3) -: 8] = a3 ^ all ^ xt(a3 ^ a0);
		end
		return o;
	endfunction

	function automatic blk_t next_key(input blk_t k, input logic [7:0] rc);
		blk_t n;
		logic [31:0] w, t;
		t = k[31:0];
		w = {FWD_SUB[t[23:16]] ^ rc, FWD_SUB[t[15:8]], FWD_SUB[t[7:0]], FWD_SUB[t[31:24]]};
		n[127:96] = k[127:96] ^ w;
		n[95:64] = k[95:64] ^ n[127:96];
		n[63:32] = k[63:32] ^ n[95:64];
		n[31:0] = k[31:0] ^ n[63:32];
		return n;
	endfunction

endpackage

// File: design/aes_keysched.sv
// round keys expanded once per key write, one round key per cycle
module aes_keysched (
	input  logic clk,
	input  logic arst_n,
	input  aes_pkg::blk_t key,
	input  logic load,
	output aes_pkg::blk_t rk [11],
	output logic keys_ok
);
	import aes_pkg::*;

	blk_t rk_q [11];
	logic [3:0] idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 4'd1;
			for (int i = 0; i < 11; i++) rk_q[i] <= '0;
		end else if (load) begin
			rk_q[0] <= key;
			idx_q <= 4'd1;
		end else if (idx_q <= 4'(NumRounds)) begin
			rk_q[idx_q] <= next_key(rk_q[idx_q - 4'd1], RCON[idx_q - 4'd1]);
			idx_q <= idx_q + 4'd1;
		end
	end

	// all eleven round keys match the key registers
	assign keys_ok = (idx_q == 4'(NumRounds + 1)) && !load;
	assign rk = rk_q;
endmodule

// File: design/aes_round.sv
// one pipeline stage: a cipher round on the given key
module aes_round (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic v_in,
	input  logic dec_in,
	input  aes_pkg::blk_t d_in,
	input  aes_pkg::blk_t key_enc,
	input  aes_pkg::blk_t key_dec,
	input  logic last,
	output logic v_out,
	output logic dec_out,
	output aes_pkg::blk_t d_out
);
	import aes_pkg::*;

	blk_t r;
	blk_t d_s1;
	logic v_s1, dec_s1;

	always_comb begin
		r = round_fn(d_in, dec_in, last);
		if (dec_in)
			r = last ? (r ^ key_dec) : inv_mix(r ^ key_dec);
		else
			r = r ^ key_enc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= v_in;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1 <= r;
			dec_s1 <= dec_in;
		end
	end

	assign v_out = v_s1;
	assign dec_out = dec_s1;
	assign d_out = d_s1;
endmodule

// File: design/aes128_block_cipher.sv
// AES-128 encrypt/decrypt, one 128-bit block per beat and one beat per cycle while m_axis does
// not stall and the round keys are not being rebuilt. There are eleven register stages: an
// initial key-add stage then ten round stages. A write to either key register rebuilds the round
// keys one per cycle: s_axis_tready is low in the write cycle and until the rebuild is done, and
// after reset until the keys are built. A stall on m_axis holds the whole pipe in place.
module aes128_block_cipher (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [127:0] s_axis_tdata,  // data_low, data_high
	input  logic s_axis_tuser,          // kind
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [127:0] m_axis_tdata,  // result_low, result_high
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [63:0] cfg_data
);
	import aes_pkg::*;

	logic [63:0] key_high_q, key_low_q;
	logic load_q;
	blk_t rk [11];
	logic keys_ok;
	logic en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q <= '0;
			load_q <= 1'b0;
		end else begin
			load_q <= cfg_we;
			if (cfg_we && cfg_index == CFG_KEY_HIGH) key_high_q <= cfg_data;
			if (cfg_we && cfg_index == CFG_KEY_LOW) key_low_q <= cfg_data;
		end
	end

	aes_keysched u_ks (
		.clk(clk), .arst_n(arst_n), .key({key_high_q, key_low_q}), .load(load_q), .rk(rk),
		.keys_ok(keys_ok)
	);

	logic v [11];
	logic dk [11];
	blk_t d [11];
	blk_t in_blk;

	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en && keys_ok && !cfg_we;
	assign in_blk = {s_axis_tdata[63:0], s_axis_tdata[127:64]};

	blk_t d0_s1;
	logic v0_s1, k0_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v0_s1 <= 1'b0;
		else if (en) v0_s1 <= s_axis_tvalid && s_axis_tready;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			d0_s1 <= in_blk ^ (s_axis_tuser ? rk[10] : rk[0]);
			k0_s1 <= s_axis_tuser;
		end
	end
	assign v[0] = v0_s1;
	assign dk[0] = k0_s1;
	assign d[0] = d0_s1;

	for (genvar g = 0; g < NumRounds; g++) begin : g_rnd
		aes_round u_rnd (
			.clk(clk), .arst_n(arst_n), .en(en),
			.v_in(v[g]), .dec_in(dk[g]), .d_in(d[g]),
			.key_enc(rk[g + 1]), .key_dec(rk[NumRounds - 1 - g]),
			.last(g == NumRounds - 1),
			.v_out(v[g + 1]), .dec_out(dk[g + 1]), .d_out(d[g + 1])
		);
	end

	assign m_axis_tvalid = v[NumRounds];
	assign m_axis_tdata = {d[NumRounds][63:0], d[NumRounds][127:64]};
endmodule

// File: design/aes_checker.sv
module aes_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [127:0] m_axis_tdata,
	input logic cfg_we
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped under stall");
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> !s_axis_tready)
		else $error("input taken during key write");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("input taken during output stall");
endmodule

bind aes128_block_cipher aes_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
	.cfg_we(cfg_we)
);

// File: test/tb_top.sv
module tb_top;
	import aes_pkg::*;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [127:0] s_axis_tdata;
	logic s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [127:0] m_axis_tdata;
	logic cfg_we;
	logic cfg_index;
	logic [63:0] cfg_data;

	localparam int CycleLimit = 400000;

	typedef struct packed {
		logic [63:0] hi;
		logic [63:0] lo;
	} half_pair_t;

	typedef struct {
		logic kind;
		logic [63:0] data_high;
		logic [63:0] data_low;
		logic chk;
		half_pair_t want;
	} block_row_t;

	aes128_block_cipher i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	logic [7:0] sbox [256];
	logic [7:0] inv_sbox [256];
	logic [7:0] rc_tab [10] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
		8'h1b, 8'h36};
	logic [63:0] key_hi_q, key_lo_q;
	half_pair_t cipher_q [$];
	int bad;
	int src_idle_pct, snk_idle_pct;
	longint cycles;

	// sbox built from the field inverse plus the affine map
	function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] acc;
		acc = 0;
		for (int i = 0; i < 8; i++) begin
			if (b[i])
				acc ^= a;
			a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
		end
		return acc;
	endfunction

	function automatic void build_sboxes();
		logic [7:0] v, s;
		for (int x = 0; x < 256; x++) begin
			v = 0;
			for (int y = 1; y < 256; y++)
				if (gmul(x[7:0], y[7:0]) == 8'h01)
					v = y[7:0];
			s = v ^ {v[6:0], v[7]} ^ {v[5:0], v[7:6]} ^ {v[4:0], v[7:5]}
				^ {v[3:0], v[7:4]} ^ 8'h63;
			sbox[x] = s;
			inv_sbox[s] = x[7:0];
		end
	endfunction

	function automatic half_pair_t aes_block(input logic dec, input logic [63:0] dh,
			input logic [63:0] dl);
		logic [7:0] rk [176];
		logic [7:0] st [16];
		logic [7:0] tmp [16];
		logic [7:0] w [4];
		logic [7:0] t, a0, a1, a2, a3;
		half_pair_t res;
		for (int i = 0; i < 8; i++) begin
			rk[i] = key_hi_q[63-8*i -: 8];
			rk[8+i] = key_lo_q[63-8*i -: 8];
			st[i] = dh[63-8*i -: 8];
			st[8+i] = dl[63-8*i -: 8];
		end
		for (int i = 16; i < 176; i += 4) begin
			for (int j = 0; j < 4; j++)
				w[j] = rk[i-4+j];
			if (i % 16 == 0) begin
				t = w[0];
				w[0] = sbox[w[1]] ^ rc_tab[i/16-1];
				w[1] = sbox[w[2]];
				w[2] = sbox[w[3]];
				w[3] = sbox[t];
			end
			for (int j = 0; j < 4; j++)
				rk[i+j] = rk[i-16+j] ^ w[j];
		end
		for (int n = 0; n < 11; n++) begin
			// key add index: forward uses round n, inverse walks down
			for (int i = 0; i < 16; i++)
				st[i] ^= rk[16*(dec ? 10-n : n) + i];
			if (n == 10)
				break;
			for (int r = 0; r < 4; r++)
				for (int c = 0; c < 4; c++)
					tmp[r+4*c] = dec ? inv_sbox[st[r+4*((c+3*r)%4)]]
						: sbox[st[r+4*((c+r)%4)]];
			st = tmp;
			if (!dec && n < 9) begin
				for (int c = 0; c < 4; c++) begin
					a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
					st[4*c] = gmul(a0, 8'h02) ^ gmul(a1, 8'h03) ^ a2 ^ a3;
					st[4*c+1] = a0 ^ gmul(a1, 8'h02) ^ gmul(a2, 8'h03) ^ a3;
					st[4*c+2] = a0 ^ a1 ^ gmul(a2, 8'h02) ^ gmul(a3, 8'h03);
					st[4*c+3] = gmul(a0, 8'h03) ^ a1 ^ a2 ^ gmul(a3, 8'h02);
				end
			end
			if (dec && n < 9) begin
				// inverse rounds: add round key first, then inverse mix
				for (int i = 0; i < 16; i++)
					st[i] ^= rk[16*(9-n) + i];
				for (int c = 0; c < 4; c++) begin
					a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
					st[4*c] = gmul(a0, 8'h0e) ^ gmul(a1, 8'h0b) ^ gmul(a2, 8'h0d)
						^ gmul(a3, 8'h09);
					st[4*c+1] = gmul(a0, 8'h09) ^ gmul(a1, 8'h0e) ^ gmul(a2, 8'h0b)
						^ gmul(a3, 8'h0d);
					st[4*c+2] = gmul(a0, 8'h0d) ^ gmul(a1, 8'h09) ^ gmul(a2, 8'h0e)
						^ gmul(a3, 8'h0b);
					st[4*c+3] = gmul(a0, 8'h0b) ^ gmul(a1, 8'h0d) ^ gmul(a2, 8'h09)
						^ gmul(a3, 8'h0e);
				end
				// cancel the key add done at the top of the next pass
				for (int i = 0; i < 16; i++)
					st[i] ^= rk[16*(9-n) + i];
			end
		end
		for (int i = 0; i < 8; i++) begin
			res.hi[63-8*i -: 8] = st[i];
			res.lo[63-8*i -: 8] = st[8+i];
		end
		return res;
	endfunction

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CycleLimit) begin
				$display("tb_top: errors");
				$finish;
			end
		end
	end

	// result checker and receiver stalls
	initial begin
		half_pair_t exp_blk;
		m_axis_tready = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				if (cipher_q.size() == 0) begin
					$error("unexpected beat %h", m_axis_tdata);
					bad++;
				end else begin
					exp_blk = cipher_q.pop_front();
					if (m_axis_tdata[63:0] !== exp_blk.hi) begin
						$error("result_high exp %h got %h", exp_blk.hi, m_axis_tdata[63:0]);
						bad++;
					end
					if (m_axis_tdata[127:64] !== exp_blk.lo) begin
						$error("result_low exp %h got %h", exp_blk.lo, m_axis_tdata[127:64]);
						bad++;
					end
				end
			end
			@(negedge clk);
			m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	task automatic write_key(input logic idx, input logic [63:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_KEY_HIGH)
			key_hi_q = v;
		else
			key_lo_q = v;
		@(negedge clk);
	endtask

	task automatic drain_and_settle();
		s_axis_tvalid <= 1'b0;
		while (cipher_q.size() != 0)
			@(negedge clk);
		repeat (14) @(negedge clk);
	endtask

	task automatic send_block(input block_row_t row);
		half_pair_t p;
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser <= row.kind;
		s_axis_tdata <= {row.data_low, row.data_high};
		p = aes_block(row.kind, row.data_high, row.data_low);
		if (row.chk && p !== row.want) begin
			$error("result exp %h got %h", row.want, p);
			bad++;
		end
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		cipher_q.push_back(p);
		@(negedge clk);
	endtask

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	initial begin
		block_row_t rows [$];
		block_row_t r;
		bad = 0;
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = 0;
		s_axis_tuser = 0;
		cfg_we = 0;
		cfg_index = 0;
		cfg_data = 0;
		key_hi_q = 0;
		key_lo_q = 0;
		src_idle_pct = 21;
		snk_idle_pct = 47;
		build_sboxes();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		repeat (12) @(negedge clk);

		// all-zero key after reset: known encryption of the zero block and its decryption, plus unchecked blocks
		rows.push_back('{KIND_ENC, 64'h0, 64'h0, 1'b1,
			'{64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e}});
		rows.push_back('{KIND_DEC, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e, 1'b1,
			'{64'h0, 64'h0}});
		rows.push_back('{KIND_ENC, '1, '1, 1'b0, '{64'h0, 64'h0}});
		rows.push_back('{KIND_DEC, '1, '1, 1'b0, '{64'h0, 64'h0}});
		rows.push_back('{KIND_DEC, 64'h0, 64'h0, 1'b0, '{64'h0, 64'h0}});
		foreach (rows[i])
			send_block(rows[i]);
		drain_and_settle();

		// standard vector key
		write_key(CFG_KEY_HIGH, 64'h000102030405060f ^ 64'h0000000000000000 ^ 64'h7);
		write_key(CFG_KEY_HIGH, 64'h0001020304050607);
		write_key(CFG_KEY_LOW, 64'h08090a0b0c0d0e0f);
		repeat (12) @(negedge clk);
		rows = {};
		rows.push_back('{KIND_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1,
			'{64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a}});
		rows.push_back('{KIND_DEC, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b1,
			'{64'h0011223344556677, 64'h8899aabbccddeeff}});
		for (int b = 0; b < 8; b++)
			rows.push_back('{b[0], 64'h8000000000000000 >> (b*9), 64'h1 << (b*8), 1'b0,
				'{64'h0, 64'h0}});
		foreach (rows[i])
			send_block(rows[i]);
		drain_and_settle();

		// extreme key, all ones
		write_key(CFG_KEY_HIGH, '1);
		write_key(CFG_KEY_LOW, '1);
		repeat (12) @(negedge clk);
		for (int i = 0; i < 4; i++) begin
			r = '{i[0], (i[1] ? '1 : '0), (i[1] ? '0 : '1), 1'b0, '{64'h0, 64'h0}};
			send_block(r);
		end
		drain_and_settle();

		// random: three idling regimes, new key each phase
		for (int ph = 0; ph < 6; ph++) begin
			src_idle_pct = (ph < 2) ? 21 : (ph < 4) ? 47 : 0;
			snk_idle_pct = (ph < 2) ? 47 : (ph < 4) ? 21 : 0;
			write_key(CFG_KEY_HIGH, rnd64());
			write_key(CFG_KEY_LOW, rnd64());
			for (int n = 0; n < 100; n++) begin
				r = '{1'($urandom_range(1)), rnd64(), rnd64(), 1'b0, '{64'h0, 64'h0}};
				send_block(r);
			end
			drain_and_settle();
		end

		repeat (20) @(negedge clk);
		if (bad == 0 && cipher_q.size() == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end
endmodule
